/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

`define ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/dbpc_pkg.sv */
`default_nettype none

package dbpc_pkg;

  localparam int Channels   = 16;
  localparam int FieldW     = 16;
  localparam int SelW       = 4;
  localparam int CntW       = 18;
  localparam int PulseW     = 32;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 16;
  localparam logic [FieldW-1:0] DelayReset = FieldW'(20);

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLED     = 4'd0,
    REG_INVERT_MASK = 4'd1,
    REG_ON_DELAY    = 4'd2,
    REG_OFF_DELAY   = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [FieldW-1:0] raw_inputs;
    logic [SelW-1:0]   read_channel;
  } in_word_t;

  typedef struct packed {
    logic [FieldW-1:0] filtered_word;
    logic [FieldW-1:0] inverted_raw;
    logic [FieldW-1:0] rise_mask;
    logic [PulseW-1:0] pulse_count;
  } out_word_t;

  typedef struct packed {
    logic              filt;
    logic              rise;
    logic [PulseW-1:0] count;
  } lane_res_t;

endpackage

`default_nettype wire

/* hw/rtl/digital_input_debounce_pulse_count.sv */
// channel | signals                          | direction
// in      | in_valid_i, in_stall_o, in_word_i   | sample word in
// out     | out_valid_o, out_stall_i, out_word_o | result word out
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// one word per cycle while in_stall_o is low; while enabled, every lane updates in the cycle its word is taken
// the result is registered in the output buffer when the word is taken
// a two-entry output buffer stalls the input only when both entries hold words
// rst_ni clears config to defaults, counters and filtered state to zero
`default_nettype none

module digital_input_debounce_pulse_count #(
  parameter int CHANNELS = dbpc_pkg::Channels
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire dbpc_pkg::in_word_t             in_word_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output dbpc_pkg::out_word_t                 out_word_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [dbpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dbpc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int FieldW = dbpc_pkg::FieldW;

  logic              enabled_q;
  logic [FieldW-1:0] invert_mask_q, on_delay_q, off_delay_q;
  logic              accept, step, full;
  logic [FieldW-1:0] inverted;

  dbpc_pkg::lane_res_t lane_res [CHANNELS];
  dbpc_pkg::out_word_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= 1'b0;
      invert_mask_q <= '0;
      on_delay_q    <= dbpc_pkg::DelayReset;
      off_delay_q   <= dbpc_pkg::DelayReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dbpc_pkg::cfg_reg_e'(cfg_index_i))
        dbpc_pkg::REG_ENABLED:     enabled_q     <= cfg_data_i[0];
        dbpc_pkg::REG_INVERT_MASK: invert_mask_q <= FieldW'(cfg_data_i);
        dbpc_pkg::REG_ON_DELAY:    on_delay_q    <= FieldW'(cfg_data_i);
        dbpc_pkg::REG_OFF_DELAY:   off_delay_q   <= FieldW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = accept && enabled_q;
  assign inverted   = in_word_i.raw_inputs ^ invert_mask_q;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic sample;
    if (c < FieldW) begin : g_in
      assign sample = inverted[c];
    end else begin : g_zero
      assign sample = 1'b0;
    end

    dbpc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .sample_i    (sample),
      .on_delay_i  (on_delay_q),
      .off_delay_i (off_delay_q),
      .res_o       (lane_res[c])
    );
  end

  dbpc_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .lane_i     (lane_res),
    .inverted_i (inverted),
    .sel_i      (in_word_i.read_channel),
    .word_o     (result)
  );

  dbpc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .word_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/dbpc_lane.sv */
`default_nettype none

module dbpc_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          sample_i,
  input  wire logic [dbpc_pkg::FieldW-1:0]   on_delay_i,
  input  wire logic [dbpc_pkg::FieldW-1:0]   off_delay_i,
  output      dbpc_pkg::lane_res_t           res_o
);

  localparam int CntW   = dbpc_pkg::CntW;
  localparam int PulseW = dbpc_pkg::PulseW;

  logic                filt_q, filt_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PulseW-1:0]   pulse_q, pulse_d;
  logic [CntW-1:0]     inc, dec;
  logic                rise;

  assign inc = cnt_q + CntW'(1);
  assign dec = cnt_q - CntW'(1);

  always_comb begin
    filt_d = filt_q;
    cnt_d  = cnt_q;
    rise   = 1'b0;
    if (step_i) begin
      if (sample_i) begin
        if (!inc[CntW-1]) begin
          rise   = !filt_q;
          filt_d = 1'b1;
          cnt_d  = CntW'(off_delay_i);
        end else begin
          cnt_d = inc;
        end
      end else begin
        if (dec[CntW-1] || (dec == '0)) begin
          filt_d = 1'b0;
          cnt_d  = CntW'(0) - CntW'(on_delay_i);
        end else begin
          cnt_d = dec;
        end
      end
    end
    pulse_d = pulse_q + PulseW'(rise);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= 1'b0;
      cnt_q   <= '0;
      pulse_q <= '0;
    end else begin
      filt_q  <= filt_d;
      cnt_q   <= cnt_d;
      pulse_q <= pulse_d;
    end
  end

  assign res_o.filt  = filt_d;
  assign res_o.rise  = rise;
  assign res_o.count = pulse_d;

endmodule

`default_nettype wire

/* hw/rtl/dbpc_merge.sv */
`default_nettype none

module dbpc_merge #(
  parameter int CHANNELS = dbpc_pkg::Channels
) (
  input  wire dbpc_pkg::lane_res_t           lane_i [CHANNELS],
  input  wire logic [dbpc_pkg::FieldW-1:0]   inverted_i,
  input  wire logic [dbpc_pkg::SelW-1:0]     sel_i,
  output dbpc_pkg::out_word_t                word_o
);

  localparam int FieldW = dbpc_pkg::FieldW;

  logic [FieldW-1:0]           filt;
  logic [FieldW-1:0]           rises;
  logic [dbpc_pkg::PulseW-1:0] count;

  for (genvar c = 0; c < FieldW; c++) begin : g_bit
    if (c < CHANNELS) begin : g_used
      assign filt[c]  = lane_i[c].filt;
      assign rises[c] = lane_i[c].rise;
    end else begin : g_unused
      assign filt[c]  = 1'b0;
      assign rises[c] = 1'b0;
    end
  end

  // channel select, zero when read_channel has no lane
  always_comb begin
    count = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(sel_i) == c) begin
        count = lane_i[c].count;
      end
    end
  end

  assign word_o.filtered_word = filt;
  assign word_o.inverted_raw  = inverted_i;
  assign word_o.rise_mask     = rises;
  assign word_o.pulse_count   = count;

endmodule

`default_nettype wire

/* hw/rtl/dbpc_outbuf.sv */
`default_nettype none

module dbpc_outbuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire dbpc_pkg::out_word_t word_i,
  output      logic                full_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output dbpc_pkg::out_word_t      out_word_o
);

  dbpc_pkg::out_word_t out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                take;

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_valid_q || take) begin
        out_q <= word_i;
      end else begin
        skid_q <= word_i;
      end
    end else if (take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/dbpc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module dbpc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire dbpc_pkg::out_word_t out_word_o
);

  `ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word_o))
  `ASSERT_SAME(a_stall_needs_word, in_stall_o, out_valid_o)
  `ASSERT_SAME(a_rise_is_high, out_valid_o, ~|(out_word_o.rise_mask & ~out_word_o.filtered_word))

endmodule

bind digital_input_debounce_pulse_count dbpc_checker u_dbpc_checker (.*);

`default_nettype wire
